>>> hdl/urb_pkg.sv
`timescale 1ns / 1ps

package urb_pkg;

  // Item operations
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;
  localparam logic [1:0] OP_TX    = 2'd3;

  // Register offsets
  localparam logic [2:0] REG_DATA = 3'd0;
  localparam logic [2:0] REG_IER  = 3'd1;
  localparam logic [2:0] REG_IIR  = 3'd2;
  localparam logic [2:0] REG_LCR  = 3'd3;
  localparam logic [2:0] REG_MCR  = 3'd4;
  localparam logic [2:0] REG_LSR  = 3'd5;
  localparam logic [2:0] REG_MSR  = 3'd6;
  localparam logic [2:0] REG_SCR  = 3'd7;

  // Bit positions
  localparam int LCR_DLAB_BIT  = 7;
  localparam int FCR_EN_BIT    = 0;
  localparam int FCR_CLR_RX    = 1;
  localparam int FCR_CLR_TX    = 2;
  localparam int IER_RX_BIT    = 0;
  localparam int IER_THRE_BIT  = 1;
  localparam int IER_LINE_BIT  = 2;

  // Interrupt identification codes
  localparam logic [3:0] IID_LINE = 4'h6;
  localparam logic [3:0] IID_RX   = 4'h4;
  localparam logic [3:0] IID_THRE = 4'h2;
  localparam logic [3:0] IID_NONE = 4'h1;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
    logic       rx_parity_error;
    logic       rx_framing_error;
    logic       rx_break;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [15:0] divisor;
    logic [7:0]  line_format;
  } out_item_t;

  // Receive trigger level in bytes for the FCR trigger field
  function automatic logic [3:0] trig_level(input logic [1:0] code);
    logic [3:0] lvl;
    case (code)
      2'd0:    lvl = 4'd1;
      2'd1:    lvl = 4'd4;
      2'd2:    lvl = 4'd8;
      default: lvl = 4'd14;
    endcase
    return lvl;
  endfunction

endpackage

>>> hdl/urb_ram.sv
`timescale 1ns / 1ps

module urb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/uart_register_block.sv
`timescale 1ns / 1ps
// An accepted item waits in the pipeline stage for its memory read, then
// moves on when the output register can advance. Throughput: one item per
// cycle while the output is not stalled; the receive and transmit FIFOs each
// have one write and one registered read port; every item uses at most one.
// Reset (rst_n low, synchronous) clears state and valid flags and both FIFOs;
// the FIFO memories are not cleared, since no entry is read before written.
module uart_register_block #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  urb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output urb_pkg::out_item_t out_item
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int LW = (CW > 4) ? CW : 4;

  // Architectural state
  logic [7:0]    lcr_r, lcr_nxt;
  logic [3:0]    ier_r, ier_nxt;
  logic [4:0]    mcr_r, mcr_nxt;
  logic [7:0]    scr_r, scr_nxt;
  logic [15:0]   dl_r, dl_nxt;
  logic          fifo_mode_r, fifo_mode_nxt;
  logic [1:0]    rx_trig_r, rx_trig_nxt;
  logic [AW-1:0] rx_head_r, rx_head_nxt;
  logic [CW-1:0] rx_fill_r, rx_fill_nxt;
  logic [AW-1:0] tx_head_r, tx_head_nxt;
  logic [CW-1:0] tx_fill_r, tx_fill_nxt;
  logic [3:0]    lerr_r, lerr_nxt;
  logic          thre_r, thre_nxt;

  // Pipeline stage between memory read and output register
  logic          a_valid_r;
  logic [7:0]    a_rd_r;
  logic          a_sel_rx_r;
  logic          a_sel_tx_r;
  logic          a_irq_r;
  logic [15:0]   a_dl_r;
  logic [7:0]    a_lcr_r;
  logic [7:0]    a_rd_nxt;
  logic          irq_nxt;

  logic          out_valid_r;
  urb_pkg::out_item_t out_r;

  // Memory ports
  logic          rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
  logic [AW-1:0] rx_wr_addr, tx_wr_addr;
  logic [7:0]    rx_wr_data, tx_wr_data, rx_rd_data, tx_rd_data;

  logic          in_accept, a_move, out_adv;
  logic          dlab;
  logic [3:0]    iid_cur;
  logic [7:0]    lsr;
  logic [7:0]    rx_val;
  logic          clr_rx, clr_tx, fcr_en;

  // Handshake
  assign out_adv   = !out_valid_r || !out_stall;
  assign a_move    = a_valid_r && out_adv;
  assign in_stall  = a_valid_r && !out_adv;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [CW-1:0] n);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(n);
    if (s >= SW'(FIFO_DEPTH)) begin
      s = s - SW'(FIFO_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [CW-1:0] cap(input logic mode);
    return mode ? CW'(FIFO_DEPTH) : CW'(1);
  endfunction

  // Interrupt identification over a given state
  function automatic logic [3:0] int_id(input logic [3:0] ier, input logic [3:0] lerr,
                                        input logic mode, input logic [1:0] trig,
                                        input logic [CW-1:0] fill, input logic thre);
    logic [LW-1:0] lvl;
    logic [3:0]    id;
    lvl = LW'(urb_pkg::trig_level(trig));
    if (lvl > LW'(FIFO_DEPTH)) begin
      lvl = LW'(FIFO_DEPTH);
    end
    if (!mode) begin
      lvl = LW'(1);
    end
    if (ier[urb_pkg::IER_LINE_BIT] && (lerr != 4'd0)) begin
      id = urb_pkg::IID_LINE;
    end else if (ier[urb_pkg::IER_RX_BIT] && (LW'(fill) >= lvl)) begin
      id = urb_pkg::IID_RX;
    end else if (ier[urb_pkg::IER_THRE_BIT] && thre) begin
      id = urb_pkg::IID_THRE;
    end else begin
      id = urb_pkg::IID_NONE;
    end
    return id;
  endfunction

  assign dlab    = lcr_r[urb_pkg::LCR_DLAB_BIT];
  assign iid_cur = int_id(ier_r, lerr_r, fifo_mode_r, rx_trig_r, rx_fill_r, thre_r);
  assign lsr     = {fifo_mode_r && (lerr_r[3:1] != 3'd0), (tx_fill_r == '0),
                    (tx_fill_r == '0), lerr_r, (rx_fill_r != '0)};
  assign rx_val  = in_item.rx_break ? 8'd0 : in_item.rx_byte;
  assign fcr_en  = in_item.write_data[urb_pkg::FCR_EN_BIT];
  assign clr_rx  = (fcr_en != fifo_mode_r) || (fcr_en && in_item.write_data[urb_pkg::FCR_CLR_RX]);
  assign clr_tx  = (fcr_en != fifo_mode_r) || (fcr_en && in_item.write_data[urb_pkg::FCR_CLR_TX]);

  // Decode the item: next state, memory accesses and result fields
  always_comb begin
    lcr_nxt       = lcr_r;
    ier_nxt       = ier_r;
    mcr_nxt       = mcr_r;
    scr_nxt       = scr_r;
    dl_nxt        = dl_r;
    fifo_mode_nxt = fifo_mode_r;
    rx_trig_nxt   = rx_trig_r;
    rx_head_nxt   = rx_head_r;
    rx_fill_nxt   = rx_fill_r;
    tx_head_nxt   = tx_head_r;
    tx_fill_nxt   = tx_fill_r;
    lerr_nxt      = lerr_r;
    thre_nxt      = thre_r;
    a_rd_nxt      = 8'd0;
    rx_wr_en      = 1'b0;
    rx_wr_addr    = ptr_add(rx_head_r, rx_fill_r);
    rx_wr_data    = rx_val;
    rx_rd_en      = 1'b0;
    tx_wr_en      = 1'b0;
    tx_wr_addr    = ptr_add(tx_head_r, tx_fill_r);
    tx_wr_data    = in_item.write_data;
    tx_rd_en      = 1'b0;

    case (in_item.operation)
      urb_pkg::OP_READ: begin
        case (in_item.reg_offset)
          urb_pkg::REG_DATA: begin
            if (dlab) begin
              a_rd_nxt = dl_r[7:0];
            end else if (rx_fill_r != '0) begin
              rx_rd_en    = in_accept;
              rx_head_nxt = ptr_inc(rx_head_r);
              rx_fill_nxt = rx_fill_r - CW'(1);
            end
          end
          urb_pkg::REG_IER: begin
            a_rd_nxt = dlab ? dl_r[15:8] : {4'd0, ier_r};
          end
          urb_pkg::REG_IIR: begin
            if (iid_cur == urb_pkg::IID_THRE) begin
              thre_nxt = 1'b0;
            end
            a_rd_nxt = {{2{fifo_mode_r}}, 2'b00, iid_cur};
          end
          urb_pkg::REG_LCR: a_rd_nxt = lcr_r;
          urb_pkg::REG_MCR: a_rd_nxt = {3'd0, mcr_r};
          urb_pkg::REG_LSR: begin
            a_rd_nxt = lsr;
            lerr_nxt = 4'd0;
          end
          urb_pkg::REG_SCR: a_rd_nxt = scr_r;
          default:          a_rd_nxt = 8'd0;
        endcase
      end
      urb_pkg::OP_WRITE: begin
        case (in_item.reg_offset)
          urb_pkg::REG_DATA: begin
            if (dlab) begin
              dl_nxt[7:0] = in_item.write_data;
            end else if (tx_fill_r < cap(fifo_mode_r)) begin
              tx_wr_en    = in_accept;
              tx_fill_nxt = tx_fill_r + CW'(1);
              thre_nxt    = 1'b0;
            end
          end
          urb_pkg::REG_IER: begin
            if (dlab) begin
              dl_nxt[15:8] = in_item.write_data;
            end else begin
              ier_nxt = in_item.write_data[3:0];
              if (!ier_r[urb_pkg::IER_THRE_BIT] && in_item.write_data[urb_pkg::IER_THRE_BIT]
                  && (tx_fill_r == '0)) begin
                thre_nxt = 1'b1;
              end
            end
          end
          urb_pkg::REG_IIR: begin
            fifo_mode_nxt = fcr_en;
            if (clr_rx) begin
              rx_head_nxt = '0;
              rx_fill_nxt = '0;
            end
            if (clr_tx) begin
              if (tx_fill_r != '0) begin
                thre_nxt = 1'b1;
              end
              tx_head_nxt = '0;
              tx_fill_nxt = '0;
            end
            if (fcr_en) begin
              rx_trig_nxt = in_item.write_data[7:6];
            end
          end
          urb_pkg::REG_LCR: lcr_nxt = in_item.write_data;
          urb_pkg::REG_MCR: mcr_nxt = in_item.write_data[4:0];
          urb_pkg::REG_SCR: scr_nxt = in_item.write_data;
          default: ;
        endcase
      end
      urb_pkg::OP_RX: begin
        lerr_nxt = lerr_r | {in_item.rx_break, in_item.rx_framing_error,
                             in_item.rx_parity_error, 1'b0};
        if (rx_fill_r < cap(fifo_mode_r)) begin
          rx_wr_en    = in_accept;
          rx_fill_nxt = rx_fill_r + CW'(1);
        end else begin
          lerr_nxt[0] = 1'b1;
          if (!fifo_mode_r) begin
            rx_wr_en   = in_accept;
            rx_wr_addr = rx_head_r;
          end
        end
      end
      default: begin
        if (tx_fill_r != '0) begin
          tx_rd_en    = in_accept;
          tx_head_nxt = ptr_inc(tx_head_r);
          tx_fill_nxt = tx_fill_r - CW'(1);
          if (tx_fill_r == CW'(1)) begin
            thre_nxt = 1'b1;
          end
        end
      end
    endcase

    irq_nxt = int_id(ier_nxt, lerr_nxt, fifo_mode_nxt, rx_trig_nxt, rx_fill_nxt, thre_nxt)
              != urb_pkg::IID_NONE;
  end

  // Update state on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcr_r       <= '0;
      ier_r       <= '0;
      mcr_r       <= '0;
      scr_r       <= '0;
      dl_r        <= '0;
      fifo_mode_r <= 1'b0;
      rx_trig_r   <= '0;
      rx_head_r   <= '0;
      rx_fill_r   <= '0;
      tx_head_r   <= '0;
      tx_fill_r   <= '0;
      lerr_r      <= '0;
      thre_r      <= 1'b0;
    end else if (in_accept) begin
      lcr_r       <= lcr_nxt;
      ier_r       <= ier_nxt;
      mcr_r       <= mcr_nxt;
      scr_r       <= scr_nxt;
      dl_r        <= dl_nxt;
      fifo_mode_r <= fifo_mode_nxt;
      rx_trig_r   <= rx_trig_nxt;
      rx_head_r   <= rx_head_nxt;
      rx_fill_r   <= rx_fill_nxt;
      tx_head_r   <= tx_head_nxt;
      tx_fill_r   <= tx_fill_nxt;
      lerr_r      <= lerr_nxt;
      thre_r      <= thre_nxt;
    end
  end

  // Hold the item while its memory read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_accept) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_rd_r     <= a_rd_nxt;
      a_sel_rx_r <= rx_rd_en;
      a_sel_tx_r <= tx_rd_en;
      a_irq_r    <= irq_nxt;
      a_dl_r     <= dl_nxt;
      a_lcr_r    <= lcr_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      out_r.read_data   <= a_sel_rx_r ? rx_rd_data : a_rd_r;
      out_r.irq         <= a_irq_r;
      out_r.tx_valid    <= a_sel_tx_r;
      out_r.tx_byte     <= a_sel_tx_r ? tx_rd_data : 8'd0;
      out_r.divisor     <= a_dl_r;
      out_r.line_format <= a_lcr_r;
    end
  end

  urb_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_rx_ram (
    .clk     (clk),
    .wr_en   (rx_wr_en),
    .wr_addr (rx_wr_addr),
    .wr_data (rx_wr_data),
    .rd_en   (rx_rd_en),
    .rd_addr (rx_head_r),
    .rd_data (rx_rd_data)
  );

  urb_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
    .clk     (clk),
    .wr_en   (tx_wr_en),
    .wr_addr (tx_wr_addr),
    .wr_data (tx_wr_data),
    .rd_en   (tx_rd_en),
    .rd_addr (tx_head_r),
    .rd_data (tx_rd_data)
  );

`ifndef SYNTHESIS
  a_rx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rx_fill_r <= cap(fifo_mode_r))
    else $error("receive fill exceeds capacity");

  a_tx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tx_fill_r <= cap(fifo_mode_r))
    else $error("transmit fill exceeds capacity");

  a_thre_empty: assert property (@(posedge clk) disable iff (!rst_n)
    thre_r |-> (tx_fill_r == '0))
    else $error("THRE pending with data in transmit FIFO");

  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en}) <= 1)
    else $error("item uses more than one memory port");

  a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && a_sel_rx_r && !a_move) |=> $stable(rx_rd_data))
    else $error("receive read data changed while item waits");
`endif

endmodule

>>> test/urb_checker.sv
`timescale 1ns / 1ps

module urb_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  urb_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  urb_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending
);

  localparam int DEPTH = 16;

  // Line error flag positions, as they sit in the error register
  localparam int ERR_OE = 0;
  localparam int ERR_PE = 1;
  localparam int ERR_FE = 2;
  localparam int ERR_BI = 3;

  // Line status bit positions
  localparam int LSR_DR       = 0;
  localparam int LSR_THRE     = 5;
  localparam int LSR_TX_IDLE  = 6;
  localparam int LSR_FIFO_ERR = 7;

  // Shadow copy of the register file and FIFOs
  logic [7:0]  lcr;
  logic [3:0]  ier;
  logic [4:0]  mcr;
  logic [7:0]  scr;
  logic [15:0] dl;
  logic        fifo_on;
  logic [1:0]  trig_sel;
  logic [7:0]  rx_mem [DEPTH];
  logic [7:0]  tx_mem [DEPTH];
  int          rx_rd, rx_cnt, tx_rd, tx_cnt;
  logic [3:0]  lerr;
  logic        thre;

  urb_pkg::out_item_t uart_results_q [$];
  int                 errs;

  assign fail_count = errs;
  assign pending    = uart_results_q.size();

  function automatic int fifo_room();
    return fifo_on ? DEPTH : 1;
  endfunction

  function automatic int rx_trigger_bytes();
    int lvl;
    if (!fifo_on) return 1;
    lvl = int'(urb_pkg::trig_level(trig_sel));
    return (lvl > DEPTH) ? DEPTH : lvl;
  endfunction

  // Highest-priority pending interrupt
  function automatic logic [3:0] pending_iid();
    if (ier[urb_pkg::IER_LINE_BIT] && lerr != 4'd0) return urb_pkg::IID_LINE;
    if (ier[urb_pkg::IER_RX_BIT] && rx_cnt >= rx_trigger_bytes()) return urb_pkg::IID_RX;
    if (ier[urb_pkg::IER_THRE_BIT] && thre) return urb_pkg::IID_THRE;
    return urb_pkg::IID_NONE;
  endfunction

  function automatic void flush_rx();
    rx_rd  = 0;
    rx_cnt = 0;
  endfunction

  function automatic void flush_tx();
    if (tx_cnt != 0) thre = 1'b1;
    tx_rd  = 0;
    tx_cnt = 0;
  endfunction

  function automatic logic [7:0] reg_read(input logic [2:0] offs);
    logic [7:0] v;
    logic [3:0] id;
    v = 8'd0;
    case (offs)
      urb_pkg::REG_DATA: begin
        if (lcr[urb_pkg::LCR_DLAB_BIT]) begin
          v = dl[7:0];
        end else if (rx_cnt != 0) begin
          v      = rx_mem[rx_rd];
          rx_rd  = (rx_rd + 1) % DEPTH;
          rx_cnt = rx_cnt - 1;
        end
      end
      urb_pkg::REG_IER: v = lcr[urb_pkg::LCR_DLAB_BIT] ? dl[15:8] : {4'd0, ier};
      urb_pkg::REG_IIR: begin
        id = pending_iid();
        if (id == urb_pkg::IID_THRE) thre = 1'b0;
        v = {fifo_on, fifo_on, 2'b00, id};
      end
      urb_pkg::REG_LCR: v = lcr;
      urb_pkg::REG_MCR: v = {3'd0, mcr};
      urb_pkg::REG_LSR: begin
        v[LSR_DR]  = (rx_cnt != 0);
        v[4:1]     = lerr;
        v[LSR_THRE] = (tx_cnt == 0);
        v[LSR_TX_IDLE] = (tx_cnt == 0);
        v[LSR_FIFO_ERR] = fifo_on && (lerr[ERR_BI:ERR_PE] != 3'd0);
        lerr = 4'd0;
      end
      urb_pkg::REG_SCR: v = scr;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic void reg_write(input logic [2:0] offs, input logic [7:0] d);
    logic [3:0] old_ier;
    case (offs)
      urb_pkg::REG_DATA: begin
        if (lcr[urb_pkg::LCR_DLAB_BIT]) begin
          dl[7:0] = d;
        end else if (tx_cnt < fifo_room()) begin
          tx_mem[(tx_rd + tx_cnt) % DEPTH] = d;
          tx_cnt = tx_cnt + 1;
          thre   = 1'b0;
        end
      end
      urb_pkg::REG_IER: begin
        if (lcr[urb_pkg::LCR_DLAB_BIT]) begin
          dl[15:8] = d;
        end else begin
          old_ier = ier;
          ier     = d[3:0];
          if (!old_ier[urb_pkg::IER_THRE_BIT] && ier[urb_pkg::IER_THRE_BIT] && tx_cnt == 0)
            thre = 1'b1;
        end
      end
      urb_pkg::REG_IIR: begin
        // FCR: toggling the enable flushes both sides
        if (d[urb_pkg::FCR_EN_BIT] != fifo_on) begin
          flush_rx();
          flush_tx();
          fifo_on = d[urb_pkg::FCR_EN_BIT];
        end
        if (d[urb_pkg::FCR_EN_BIT]) begin
          if (d[urb_pkg::FCR_CLR_RX]) flush_rx();
          if (d[urb_pkg::FCR_CLR_TX]) flush_tx();
          trig_sel = d[7:6];
        end
      end
      urb_pkg::REG_LCR: lcr = d;
      urb_pkg::REG_MCR: mcr = d[4:0];
      urb_pkg::REG_SCR: scr = d;
      default: ;
    endcase
  endfunction

  function automatic void line_byte(input urb_pkg::in_item_t it);
    logic [7:0] v;
    v = it.rx_break ? 8'd0 : it.rx_byte;
    lerr[ERR_PE] = lerr[ERR_PE] | it.rx_parity_error;
    lerr[ERR_FE] = lerr[ERR_FE] | it.rx_framing_error;
    lerr[ERR_BI] = lerr[ERR_BI] | it.rx_break;
    if (rx_cnt < fifo_room()) begin
      rx_mem[(rx_rd + rx_cnt) % DEPTH] = v;
      rx_cnt = rx_cnt + 1;
    end else begin
      // Overrun: FIFO mode drops the byte, holding register mode overwrites
      lerr[ERR_OE] = 1'b1;
      if (!fifo_on) rx_mem[rx_rd] = v;
    end
  endfunction

  // Apply one item to the shadow state and return the result it causes
  function automatic urb_pkg::out_item_t next_uart_outputs(input urb_pkg::in_item_t it);
    urb_pkg::out_item_t r;
    r = '0;
    case (it.operation)
      urb_pkg::OP_READ:  r.read_data = reg_read(it.reg_offset);
      urb_pkg::OP_WRITE: reg_write(it.reg_offset, it.write_data);
      urb_pkg::OP_RX:    line_byte(it);
      default: begin
        if (tx_cnt != 0) begin
          r.tx_byte  = tx_mem[tx_rd];
          r.tx_valid = 1'b1;
          tx_rd  = (tx_rd + 1) % DEPTH;
          tx_cnt = tx_cnt - 1;
          if (tx_cnt == 0) thre = 1'b1;
        end
      end
    endcase
    r.irq         = (pending_iid() != urb_pkg::IID_NONE);
    r.divisor     = dl;
    r.line_format = lcr;
    return r;
  endfunction

  initial errs = 0;

  always @(posedge clk) begin
    urb_pkg::out_item_t want;
    if (!rst_n) begin
      lcr = '0; ier = '0; mcr = '0; scr = '0; dl = '0;
      fifo_on = 1'b0; trig_sel = '0;
      rx_rd = 0; rx_cnt = 0; tx_rd = 0; tx_cnt = 0;
      lerr = '0; thre = 1'b0;
      uart_results_q.delete();
    end else begin
      // Compare the result first: it belongs to an earlier item
      if (out_valid && !out_stall) begin
        if (uart_results_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result rd=%02h irq=%0b txv=%0b txb=%02h div=%04h lcr=%02h",
                   $time, out_item.read_data, out_item.irq, out_item.tx_valid,
                   out_item.tx_byte, out_item.divisor, out_item.line_format);
        end else begin
          want = uart_results_q.pop_front();
          if (out_item.read_data !== want.read_data || out_item.irq !== want.irq ||
              out_item.tx_valid !== want.tx_valid || out_item.tx_byte !== want.tx_byte ||
              out_item.divisor !== want.divisor || out_item.line_format !== want.line_format)
          begin
            errs++;
            $display("%0t: mismatch expected rd=%02h irq=%0b txv=%0b txb=%02h div=%04h lcr=%02h",
                     $time, want.read_data, want.irq, want.tx_valid, want.tx_byte,
                     want.divisor, want.line_format);
            $display("%0t:          actual rd=%02h irq=%0b txv=%0b txb=%02h div=%04h lcr=%02h",
                     $time, out_item.read_data, out_item.irq, out_item.tx_valid,
                     out_item.tx_byte, out_item.divisor, out_item.line_format);
          end
        end
      end
      if (in_valid && !in_stall) uart_results_q.push_back(next_uart_outputs(in_item));
    end
  end

endmodule

>>> test/tb_uart_register_block.sv
`timescale 1ns / 1ps

module tb_uart_register_block;

  localparam int ITEM_TOTAL   = 1650;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  // Traffic mixes for the random bursts
  localparam int FLOW_RX    = 0;
  localparam int FLOW_TX    = 1;
  localparam int FLOW_REGS  = 2;
  localparam int FLOW_NOISE = 3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  urb_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  urb_pkg::out_item_t out_item;
  int                 fail_count;
  int                 pending;

  int          sent;
  bit          idle_on;
  bit          stall_calm;
  int unsigned hold_cycles;
  int          cycle_cnt;

  uart_register_block uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  urb_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic urb_pkg::in_item_t bus_item(input logic [1:0] op,
                                                 input logic [2:0] offs,
                                                 input logic [7:0] data);
    urb_pkg::in_item_t it;
    it            = '0;
    it.operation  = op;
    it.reg_offset = offs;
    it.write_data = data;
    return it;
  endfunction

  function automatic urb_pkg::in_item_t line_item(input logic [7:0] b, input logic pe,
                                                  input logic fe, input logic brk);
    urb_pkg::in_item_t it;
    it                  = '0;
    it.operation        = urb_pkg::OP_RX;
    it.rx_byte          = b;
    it.rx_parity_error  = pe;
    it.rx_framing_error = fe;
    it.rx_break         = brk;
    return it;
  endfunction

  // Draw one random item, shaped by the current traffic mix
  function automatic urb_pkg::in_item_t pick_item(input int flow);
    urb_pkg::in_item_t it;
    int unsigned       r;
    it.operation        = 2'($urandom);
    it.reg_offset       = 3'($urandom);
    it.write_data       = 8'($urandom);
    it.rx_byte          = 8'($urandom);
    it.rx_parity_error  = ($urandom_range(0, 7) == 0);
    it.rx_framing_error = ($urandom_range(0, 7) == 0);
    it.rx_break         = ($urandom_range(0, 9) == 0);
    r = $urandom_range(0, 99);
    case (flow)
      FLOW_RX: begin
        if (r < 50) begin
          it.operation = urb_pkg::OP_RX;
        end else begin
          it.operation  = urb_pkg::OP_READ;
          it.reg_offset = (r < 85) ? urb_pkg::REG_DATA :
                          (r < 93) ? urb_pkg::REG_LSR : urb_pkg::REG_IIR;
        end
      end
      FLOW_TX: begin
        if (r < 55) begin
          it.operation  = urb_pkg::OP_WRITE;
          it.reg_offset = urb_pkg::REG_DATA;
        end else if (r < 85) begin
          it.operation = urb_pkg::OP_TX;
        end else begin
          it.operation  = urb_pkg::OP_READ;
          it.reg_offset = (r < 93) ? urb_pkg::REG_IIR : urb_pkg::REG_LSR;
        end
      end
      FLOW_REGS: begin
        it.operation = (r < 55) ? urb_pkg::OP_WRITE : urb_pkg::OP_READ;
        if (it.reg_offset == urb_pkg::REG_LCR) begin
          it.write_data[urb_pkg::LCR_DLAB_BIT] = ($urandom_range(0, 3) == 0);
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  // Hold the item until accepted; lower valid only when a gap follows
  task automatic send_item(input urb_pkg::in_item_t it);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Result side: after each taken result, stall for a random number of cycles (none in calm phases)
  initial begin
    out_stall  = 1'b0;
    stall_calm = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if ($urandom_range(0, 39) == 0) stall_calm = !stall_calm;
        hold_cycles = stall_calm ? 0 : $urandom_range(0, 19);
        if (hold_cycles != 0) begin
          out_stall <= 1'b1;
          repeat (hold_cycles) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Abort a hung run
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int          burst_left;
    int          flow;
    logic [7:0]  fcr;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    sent     = 0;
    idle_on  = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state, holding-register mode corners, divisor latch
    send_item(bus_item(urb_pkg::OP_READ, urb_pkg::REG_LSR, 8'h00));
    send_item(bus_item(urb_pkg::OP_READ, urb_pkg::REG_IIR, 8'h00));
    send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_IER, 8'hFF));  // THRE pending, TX empty
    send_item(bus_item(urb_pkg::OP_READ, urb_pkg::REG_IIR, 8'h00));   // reports and clears THRE
    send_item(bus_item(urb_pkg::OP_TX, urb_pkg::REG_DATA, 8'h00));    // pull from empty TX
    send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_DATA, 8'hA5));
    send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_DATA, 8'h5A)); // full TX, dropped
    send_item(bus_item(urb_pkg::OP_TX, urb_pkg::REG_DATA, 8'h00));
    send_item(bus_item(urb_pkg::OP_READ, urb_pkg::REG_DATA, 8'h00));  // empty RX read
    send_item(line_item(8'hFF, 1'b1, 1'b1, 1'b0));
    send_item(line_item(8'h3C, 1'b0, 1'b0, 1'b0));   // overrun, overwrite
    send_item(line_item(8'h77, 1'b0, 1'b0, 1'b1));   // break stores zero
    send_item(bus_item(urb_pkg::OP_READ, urb_pkg::REG_IIR, 8'h00));
    send_item(bus_item(urb_pkg::OP_READ, urb_pkg::REG_LSR, 8'h00));   // clears line errors
    send_item(bus_item(urb_pkg::OP_READ, urb_pkg::REG_DATA, 8'h00));
    send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_LCR, 8'hFF));
    send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_DATA, 8'hFF));
    send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_IER, 8'hFF));
    send_item(bus_item(urb_pkg::OP_READ, urb_pkg::REG_DATA, 8'h00));
    send_item(bus_item(urb_pkg::OP_READ, urb_pkg::REG_IER, 8'h00));
    send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_LCR, 8'h03));
    send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_MCR, 8'hFF));
    send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_SCR, 8'hFF));
    send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_MSR, 8'hFF));
    send_item(bus_item(urb_pkg::OP_READ, urb_pkg::REG_MSR, 8'h00));
    send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_IIR, 8'hC7));  // FIFOs on, trigger 14
    send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_IIR, 8'h00));  // FIFOs off again

    // Random bursts with a setup prologue for the data-path mixes
    burst_left = 0;
    flow       = FLOW_NOISE;
    while (sent < ITEM_TOTAL) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 80);
        flow       = $urandom_range(FLOW_RX, FLOW_NOISE);
        idle_on    = ($urandom_range(0, 3) != 0);
        if (flow == FLOW_RX || flow == FLOW_TX) begin
          send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_LCR, {1'b0, 7'($urandom)}));
          fcr = 8'($urandom);
          fcr[urb_pkg::FCR_EN_BIT] = ($urandom_range(0, 3) != 0);
          send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_IIR, fcr));
          send_item(bus_item(urb_pkg::OP_WRITE, urb_pkg::REG_IER, 8'($urandom)));
        end
      end
      send_item(pick_item(flow));
      burst_left--;
    end
    in_valid <= 1'b0;

    // Let the checker log the last item, drain outstanding results, then allow for the pipeline
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/urb_pkg.sv
hdl/urb_ram.sv
hdl/uart_register_block.sv
test/urb_checker.sv
test/tb_uart_register_block.sv
